>>> rtl/far_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// far_pkg
// Shared widths, register indexes and controller/datapath handshake types
// for the fractional audio resampler.
// ----------------------------------------------------------------------------
package far_pkg;

  // Sample and phase formats
  localparam int unsigned SAMPLE_W     = 16;             // signed Q1.15
  localparam int unsigned PHASE_FRAC_W = 16;
  localparam int unsigned PHASE_W      = PHASE_FRAC_W + 4; // unsigned Q4.16
  localparam int unsigned STEP_W       = 19;             // unsigned Q3.16
  localparam int unsigned MAX_OUT      = 16;
  localparam int unsigned CNT_W        = $clog2(MAX_OUT);

  localparam logic [PHASE_W-1:0] PHASE_ONE = PHASE_W'(1) << PHASE_FRAC_W;

  // Blend product: 17-bit difference by 17-bit (zero-extended) fraction
  localparam int unsigned DIFF_W = SAMPLE_W + 1;
  localparam int unsigned PROD_W = DIFF_W + PHASE_FRAC_W + 1;
  localparam logic signed [PROD_W-1:0] ROUND_HALF =
    PROD_W'(1) << (PHASE_FRAC_W - 1);

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = STEP_W;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_INTERP_MODE = 1'b1;

  localparam logic [STEP_W-1:0] PHASE_STEP_RST = STEP_W'(65536);

  localparam logic MODE_LINEAR  = 1'b0;
  localparam logic MODE_NEAREST = 1'b1;

  // Controller to datapath
  typedef struct packed {
    logic capture;  // latch the incoming beat
    logic emit;     // compute one output and load the output register
    logic commit;   // close the current input item
  } far_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic have_prev;     // a previous sample is held
    logic phase_ge_one;  // read phase already at or past the current sample
    logic stop;          // the output about to be emitted is the final one
    logic out_free;      // output register can take a beat this cycle
  } far_status_t;

endpackage

>>> rtl/fractional_audio_resampler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fractional_audio_resampler
// Linear / nearest-neighbour sample rate converter on a Q1.15 sample stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats carry one signed Q1.15 sample on s_axis_tdata; s_axis_tlast
//   ends a stream. Each beat emits up to 16 outputs whose read position lies
//   between the previous and the current sample, each moving the read phase
//   on by phase_step (Q3.16, old rate over new rate). The first sample of a
//   stream only primes the history. Output beats carry one sample on
//   m_axis_tdata; m_axis_tlast marks the final output of a last beat.
//   Configuration: cfg_we_i writes register cfg_idx_i (0 phase_step,
//   1 interp_mode) from cfg_data_i; write only while the block is idle.
// Sequence:
//   An input beat yields n outputs (0 to 16): the idle state takes the
//   beat, then the run state emits one output per cycle while the output
//   register is free, through the single blend multiplier.
//   s_axis_tready is high only between items.
// Reset: clears history and phase; phase_step returns to 1.0, mode linear.
// Stall: a held output register pauses the output sequence; the last
//   output of an item may wait while the next input beat is taken.
// ----------------------------------------------------------------------------
module fractional_audio_resampler
  import far_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [SAMPLE_W-1:0]   s_axis_tdata,   // [15:0] in_sample
  input  logic                  s_axis_tlast,   // in_last
  // output stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [SAMPLE_W-1:0]   m_axis_tdata,   // [15:0] out_sample
  output logic                  m_axis_tlast    // run_last
);

  far_cmd_t    cmd;
  far_status_t status;

  far_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  far_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_sample_i  (s_axis_tdata),
    .in_last_i    (s_axis_tlast),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_sample_o (m_axis_tdata),
    .out_last_o   (m_axis_tlast)
  );

endmodule

>>> rtl/far_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// far_ctrl
// Sequencer: takes one input beat, then steps the datapath once per output
// beat until the read phase passes the current sample or the output cap is hit.
// ----------------------------------------------------------------------------
module far_ctrl
  import far_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  far_status_t status_i,
  output far_cmd_t    cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_RUN;
        end
      end
      ST_RUN: begin
        if (!status_i.have_prev || status_i.phase_ge_one) begin
          // no output falls inside this interval
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end else if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.stop) begin
            cmd_o.commit = 1'b1;
            state_d      = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/far_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// far_datapath
// Configuration registers, sample history, read phase, interpolator and
// the output register.
// ----------------------------------------------------------------------------
module far_datapath
  import far_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [SAMPLE_W-1:0]   in_sample_i,
  input  logic                  in_last_i,
  input  far_cmd_t              cmd_i,
  output far_status_t           status_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [SAMPLE_W-1:0]   out_sample_o,
  output logic                  out_last_o
);

  logic [STEP_W-1:0]   step_q;
  logic                mode_q;
  logic [SAMPLE_W-1:0] prev_q, prev_d;
  logic [SAMPLE_W-1:0] cur_q;
  logic                last_q;
  logic                have_q, have_d;
  logic [PHASE_W-1:0]  phase_q, phase_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic                ovld_q;
  logic [SAMPLE_W-1:0] osmp_q;
  logic                olast_q;

  logic [PHASE_W-1:0]      phase_nxt;
  logic [PHASE_W-1:0]      phase_base;
  logic [PHASE_FRAC_W-1:0] frac;
  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_rnd;
  logic [DIFF_W-1:0]        blend;
  logic [SAMPLE_W-1:0]      y;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= PHASE_STEP_RST;
      mode_q <= MODE_LINEAR;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_PHASE_STEP:  step_q <= cfg_data_i[STEP_W-1:0];
        REG_INTERP_MODE: mode_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Phase advance and stop test
  assign phase_nxt = phase_q + PHASE_W'(step_q);
  assign frac      = phase_q[PHASE_FRAC_W-1:0];

  assign status_o.have_prev    = have_q;
  assign status_o.phase_ge_one = (phase_q >= PHASE_ONE);
  assign status_o.stop         = (phase_nxt >= PHASE_ONE) ||
                                 (cnt_q == CNT_W'(MAX_OUT - 1));
  assign status_o.out_free     = !ovld_q || out_ready_i;

  // Linear blend: prev + floor((cur - prev) * frac / 2^16 + 1/2)
  assign diff     = $signed({cur_q[SAMPLE_W-1], cur_q}) -
                    $signed({prev_q[SAMPLE_W-1], prev_q});
  assign prod     = PROD_W'(diff) * $signed({1'b0, frac});
  assign prod_rnd = prod + ROUND_HALF;
  assign blend    = {prev_q[SAMPLE_W-1], prev_q} +
                    prod_rnd[PHASE_FRAC_W +: DIFF_W];

  // Pick interpolated or nearest sample
  always_comb begin
    if (mode_q == MODE_NEAREST) begin
      y = frac[PHASE_FRAC_W-1] ? cur_q : prev_q;
    end else begin
      y = blend[SAMPLE_W-1:0];
    end
  end

  // Per-output and end-of-item state update
  assign phase_base = cmd_i.emit ? phase_nxt : phase_q;

  always_comb begin
    prev_d  = prev_q;
    have_d  = have_q;
    phase_d = phase_q;
    cnt_d   = cnt_q;
    if (cmd_i.emit) begin
      phase_d = phase_nxt;
      cnt_d   = cnt_q + CNT_W'(1);
    end
    if (cmd_i.commit) begin
      cnt_d = '0;
      if (last_q) begin
        prev_d  = '0;
        have_d  = 1'b0;
        phase_d = '0;
      end else begin
        prev_d  = cur_q;
        have_d  = 1'b1;
        phase_d = (phase_base >= PHASE_ONE) ? phase_base - PHASE_ONE : '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      have_q  <= 1'b0;
      phase_q <= '0;
      cnt_q   <= '0;
    end else begin
      prev_q  <= prev_d;
      have_q  <= have_d;
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
    end
  end

  // Hold the accepted beat
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cur_q  <= in_sample_i;
      last_q <= in_last_i;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovld_q <= 1'b0;
    end else if (cmd_i.emit) begin
      ovld_q <= 1'b1;
    end else if (out_ready_i) begin
      ovld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      osmp_q  <= y;
      olast_q <= last_q && status_o.stop;
    end
  end

  assign out_valid_o  = ovld_q;
  assign out_sample_o = osmp_q;
  assign out_last_o   = olast_q;

endmodule

>>> rtl/far_sva.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// far_sva
// Port-level checks for the fractional audio resampler, bound to the top.
// ----------------------------------------------------------------------------
module far_sva
  import far_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [SAMPLE_W-1:0] m_axis_tdata,
  input logic                m_axis_tlast
);

  // Hold a stalled output beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output beat dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output payload changed while stalled");

  // One item at a time: no input beat right after another
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while previous item in progress");

  // Outputs start only while an item is being worked on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("output beat appeared without an item in progress");

endmodule

bind fractional_audio_resampler far_sva u_far_sva (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

>>> sim/far_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// far_result_checker
// Watches the configuration port and both sample streams of the fractional
// audio resampler, predicts every output beat from the accepted input beats
// and compares each output beat, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module far_result_checker
  import far_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration port as driven into the block
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // input stream
  input  logic                  s_valid_i,
  input  logic                  s_ready_i,
  input  logic [SAMPLE_W-1:0]   s_data_i,   // [15:0] in_sample
  input  logic                  s_last_i,   // in_last
  // output stream
  input  logic                  m_valid_i,
  input  logic                  m_ready_i,
  input  logic [SAMPLE_W-1:0]   m_data_i,   // [15:0] out_sample
  input  logic                  m_last_i,   // run_last
  // status towards the testbench top
  output int unsigned           fail_cnt_o,
  output int unsigned           pending_o,
  output int unsigned           out_cnt_o
);

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                last;
  } out_beat_t;

  // Predicted output beats, oldest first
  out_beat_t due_beats_q[$];

  // Shadow copy of the registers and of the resampler state
  logic [STEP_W-1:0]          step_r;
  logic                       mode_r;
  logic signed [SAMPLE_W-1:0] hist_smp;
  logic                       hist_vld;
  logic [PHASE_W-1:0]         rd_phase;

  int unsigned n_fail;
  int unsigned n_out;

  // Linear blend with round half up: a + floor((b - a) * frac / 2^16 + 1/2)
  function automatic logic [SAMPLE_W-1:0] blend_q15(
    input logic signed [SAMPLE_W-1:0] a,
    input logic signed [SAMPLE_W-1:0] b,
    input logic [PHASE_FRAC_W-1:0]    frac
  );
    longint diff;
    longint prod;
    diff = longint'(b) - longint'(a);
    prod = diff * longint'(frac) + longint'(PHASE_ONE >> 1);
    return SAMPLE_W'(longint'(a) + (prod >>> PHASE_FRAC_W));
  endfunction

  // Work out every output caused by one input beat and queue it
  task automatic predict_beat(input logic signed [SAMPLE_W-1:0] cur, input logic lst);
    out_beat_t               ob;
    int                      n;
    logic [PHASE_FRAC_W-1:0] frac;
    n = 0;
    if (hist_vld) begin
      while (rd_phase < PHASE_ONE && n < MAX_OUT) begin
        frac = rd_phase[PHASE_FRAC_W-1:0];
        if (mode_r == MODE_NEAREST) begin
          // top fraction bit set means at or above one half
          ob.sample = frac[PHASE_FRAC_W-1] ? cur : hist_smp;
        end else begin
          ob.sample = blend_q15(hist_smp, cur, frac);
        end
        ob.last = 1'b0;
        due_beats_q.push_back(ob);
        n++;
        rd_phase = rd_phase + PHASE_W'(step_r);
      end
      // drop one sample of phase, or restart if the output cap was hit early
      if (rd_phase >= PHASE_ONE) begin
        rd_phase = rd_phase - PHASE_ONE;
      end else begin
        rd_phase = '0;
      end
    end
    hist_smp = cur;
    hist_vld = 1'b1;
    // end of stream: mark the final output and clear the history
    if (lst) begin
      if (n > 0) begin
        ob      = due_beats_q.pop_back();
        ob.last = 1'b1;
        due_beats_q.push_back(ob);
      end
      hist_smp = '0;
      hist_vld = 1'b0;
      rd_phase = '0;
    end
  endtask

  task automatic note_fail(input string what);
    n_fail++;
    if (n_fail <= 10) begin
      $display("[%0t] mismatch: %s", $realtime, what);
    end
  endtask

  // Track registers, predict on input beats, compare on output beats
  always @(posedge clk_i or negedge rst_ni) begin
    out_beat_t exp_beat;
    if (!rst_ni) begin
      step_r   = PHASE_STEP_RST;
      mode_r   = MODE_LINEAR;
      hist_smp = '0;
      hist_vld = 1'b0;
      rd_phase = '0;
      n_fail   = 0;
      n_out    = 0;
      due_beats_q.delete();
      fail_cnt_o <= 0;
      pending_o  <= 0;
      out_cnt_o  <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_PHASE_STEP:  step_r = cfg_data_i[STEP_W-1:0];
          REG_INTERP_MODE: mode_r = cfg_data_i[0];
          default: ;
        endcase
      end
      if (s_valid_i && s_ready_i) begin
        predict_beat(s_data_i, s_last_i);
      end
      if (m_valid_i && m_ready_i) begin
        n_out++;
        if (due_beats_q.size() == 0) begin
          note_fail($sformatf("unexpected beat sample=%h last=%b", m_data_i, m_last_i));
        end else begin
          exp_beat = due_beats_q.pop_front();
          if (exp_beat.sample !== m_data_i || exp_beat.last !== m_last_i) begin
            note_fail($sformatf("sample exp=%h act=%h, last exp=%b act=%b",
                                exp_beat.sample, m_data_i, exp_beat.last, m_last_i));
          end
        end
      end
      fail_cnt_o <= n_fail;
      pending_o  <= due_beats_q.size();
      out_cnt_o  <= n_out;
    end
  end

endmodule

>>> sim/tb_fractional_audio_resampler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fractional_audio_resampler
// Drives sample streams and register settings into the resampler, with
// bursty input and a stalling output side, and takes the verdict from the
// checker that predicts and compares every output beat.
// ----------------------------------------------------------------------------
module tb_fractional_audio_resampler;
  import far_pkg::*;

  localparam int unsigned LIMIT_CYCLES  = 400000;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned SETTLE_CYCLES = 24;

  logic                  clk_i    = 1'b0;
  logic                  rst_ni   = 1'b0;
  logic                  cfg_we   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_valid  = 1'b0;
  logic [SAMPLE_W-1:0]   s_data   = '0;
  logic                  s_last   = 1'b0;
  logic                  m_ready  = 1'b0;
  logic                  s_ready;
  logic                  m_valid;
  logic [SAMPLE_W-1:0]   m_data;
  logic                  m_last;

  int unsigned fail_cnt;
  int unsigned pending;
  int unsigned out_cnt;
  int unsigned cycle_cnt    = 0;
  int unsigned beats_sent   = 0;
  int unsigned settings_cnt = 0;
  int          burst_left   = 0;
  logic        hold_go      = 1'b0;

  fractional_audio_resampler i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tlast  (s_last),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .m_axis_tlast  (m_last)
  );

  far_result_checker i_result_chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .s_valid_i  (s_valid),
    .s_ready_i  (s_ready),
    .s_data_i   (s_data),
    .s_last_i   (s_last),
    .m_valid_i  (m_valid),
    .m_ready_i  (m_ready),
    .m_data_i   (m_data),
    .m_last_i   (m_last),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending),
    .out_cnt_o  (out_cnt)
  );

  // Clock, 8 ns period
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("Run timed out after %0d cycles", cycle_cnt);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Output side: changing stall patterns, plus one long hold-off on request
  initial begin
    int pat_kind;
    int pat_left;
    bit hold_done;
    pat_kind  = 0;
    pat_left  = 0;
    hold_done = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        m_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        if (pat_left == 0) begin
          pat_kind = $urandom_range(0, 3);
          pat_left = $urandom_range(16, 96);
        end
        pat_left--;
        case (pat_kind)
          0:       m_ready <= 1'b1;
          1:       m_ready <= 1'($urandom_range(0, 1));
          2:       m_ready <= ($urandom_range(0, 3) == 0);
          default: m_ready <= (pat_left % 3 != 0);
        endcase
      end
    end
  end

  // Offer one beat, opening a new burst after a random gap when due
  task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input logic lst);
    int gap;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 18);
      if (gap > 0) begin
        s_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_valid <= 1'b1;
    s_data  <= smp;
    s_last  <= lst;
    do @(posedge clk_i); while (!s_ready);
    beats_sent++;
  endtask

  // Stop offering, wait for every predicted beat, then let trailing work finish
  task automatic settle();
    s_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write both registers while the block is idle
  task automatic set_config(input logic [STEP_W-1:0] step, input logic mode);
    settle();
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_PHASE_STEP;
    cfg_data <= CFG_DATA_W'(step);
    @(posedge clk_i);
    cfg_idx  <= REG_INTERP_MODE;
    cfg_data <= CFG_DATA_W'(mode);
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    settings_cnt++;
  endtask

  // Sample content: full-range noise, corner values or a bounded random walk
  function automatic logic [SAMPLE_W-1:0] pick_sample(input int kind,
                                                       input logic [SAMPLE_W-1:0] prev);
    int v;
    case (kind)
      0: return SAMPLE_W'($urandom);
      1: begin
        case ($urandom_range(0, 4))
          0:       return 16'h7FFF;
          1:       return 16'h8000;
          2:       return 16'h0000;
          3:       return 16'hFFFF;
          default: return 16'h0001;
        endcase
      end
      default: begin
        v = int'($signed(prev)) + $urandom_range(0, 2048) - 1024;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return SAMPLE_W'(v);
      end
    endcase
  endfunction

  task automatic send_stream(input int len, input int kind);
    logic [SAMPLE_W-1:0] smp;
    smp = SAMPLE_W'($urandom);
    for (int i = 0; i < len; i++) begin
      smp = pick_sample(kind, smp);
      send_sample(smp, i == len - 1);
    end
  endtask

  // One setting, then streams of random length and content, each ending on a last-marked beat
  task automatic random_phase(input logic [STEP_W-1:0] step, input logic mode,
                              input int n_items, input bit hold);
    int sent;
    int len;
    set_config(step, mode);
    if (hold) hold_go <= 1'b1;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 16);
      send_stream(len, $urandom_range(0, 2));
      sent += len;
    end
  endtask

  // Stimulus and verdict
  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: a lone last-marked sample, then a full swing at unit step
    send_sample(16'h1234, 1'b1);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h0000, 1'b0);
    send_sample(16'hFFFF, 1'b1);

    // smallest step that fits the cap: sixteen blended outputs per beat between extremes
    set_config(19'd4096, MODE_LINEAR);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b1);

    // step too small to cross a sample within the output cap
    set_config(19'd3000, MODE_LINEAR);
    send_sample(16'd100, 1'b0);
    send_sample(16'hFF9C, 1'b0);
    send_sample(16'd5, 1'b1);

    // half step in nearest mode lands exactly on one half
    set_config(19'd32768, MODE_NEAREST);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h0001, 1'b0);
    send_sample(16'hFFFE, 1'b1);

    // largest step: rare outputs, stream ends on a beat that emits nothing
    set_config(19'h7FFFF, MODE_NEAREST);
    send_sample(16'h0001, 1'b0);
    send_sample(16'hFFF0, 1'b0);
    send_sample(16'h0300, 1'b0);
    send_sample(16'h8001, 1'b0);
    send_sample(16'h7FFE, 1'b0);
    send_sample(16'h0000, 1'b0);
    send_sample(16'h4000, 1'b1);

    // zero step: the phase never moves
    set_config(19'd0, MODE_LINEAR);
    send_sample(16'd5, 1'b0);
    send_sample(16'd9, 1'b1);

    // random streams over a spread of settings, the first under a long hold-off
    random_phase(19'd4096, MODE_LINEAR, 16, 1'b1);
    random_phase(19'd65536, MODE_NEAREST, 14, 1'b0);
    random_phase(19'd60211, MODE_LINEAR, 16, 1'b0);
    random_phase(19'd87381, MODE_NEAREST, 14, 1'b0);
    random_phase(19'h7FFFF, MODE_LINEAR, 16, 1'b0);
    repeat (3) begin
      random_phase(STEP_W'($urandom_range(4096, 524287)), 1'($urandom_range(0, 1)), 14, 1'b0);
    end
    settle();

    $display("Sent %0d input beats under %0d register settings, checked %0d output beats.",
             beats_sent, settings_cnt + 1, out_cnt);
    $display("Both modes were used with steps from zero to the 19-bit maximum.");
    if (fail_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/far_pkg.sv
rtl/far_ctrl.sv
rtl/far_datapath.sv
rtl/fractional_audio_resampler.sv
rtl/far_sva.sv
sim/far_result_checker.sv
sim/tb_fractional_audio_resampler.sv
